// File: rtl/akic_pkg.sv
`default_nettype none

package akic_pkg;

   localparam int ENTRIES_DEFAULT = 16;
   localparam int KEY_BYTES = 10;
   localparam int KEY_BYTES_MAX = 10;

   localparam int KEY_LOW_W = 64;
   localparam int KEY_HIGH_W = 16;
   localparam int INDEX_W = 16;
   localparam int TIME_W = 32;
   localparam int TIMEOUT_W = 31;

   localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = TIMEOUT_W'(1000 * 60);
   localparam logic signed [INDEX_W-1:0] NO_INDEX = -16'sd1;

   localparam logic [1:0] ACT_ADD = 2'd0;
   localparam logic [1:0] ACT_LOOKUP = 2'd1;
   localparam logic [1:0] ACT_DELETE = 2'd2;
   localparam logic [1:0] ACT_SWEEP = 2'd3;

   typedef struct packed {
      logic [KEY_LOW_W-1:0] key_low;
      logic [KEY_HIGH_W-1:0] key_high;
      logic [INDEX_W-1:0] index;
      logic [TIME_W-1:0] last_use;
   } entry_type;

   typedef struct packed {
      logic hit;
      logic expired;
   } cmp_result_type;

endpackage

`default_nettype wire

// File: rtl/akic_ram.sv
`default_nettype none

module akic_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]              rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

// File: rtl/akic_key_norm.sv
`default_nettype none

module akic_key_norm (
   input  wire logic [akic_pkg::KEY_LOW_W-1:0]  key_low,
   input  wire logic [akic_pkg::KEY_HIGH_W-1:0] key_high,
   output logic [akic_pkg::KEY_LOW_W-1:0]       norm_low,
   output logic [akic_pkg::KEY_HIGH_W-1:0]      norm_high
);

   localparam int RAW_W = akic_pkg::KEY_LOW_W + akic_pkg::KEY_HIGH_W;

   logic [RAW_W-1:0] raw;
   logic [RAW_W-1:0] res;

   assign raw = {key_high, key_low};

   // key ends at first zero byte
   always_comb begin
      logic live;
      live = 1'b1;
      res = '0;
      for (int b = 0; b < akic_pkg::KEY_BYTES_MAX; b++) begin
         live = live && (raw[8*b +: 8] != 8'd0) && (b < akic_pkg::KEY_BYTES);
         if (live) begin
            res[8*b +: 8] = raw[8*b +: 8];
         end
      end
   end

   assign norm_low = res[akic_pkg::KEY_LOW_W-1:0];
   assign norm_high = res[RAW_W-1:akic_pkg::KEY_LOW_W];

endmodule

`default_nettype wire

// File: rtl/akic_cmp_unit.sv
`default_nettype none

module akic_cmp_unit (
   input  wire akic_pkg::entry_type                 entry,
   input  wire logic                                slot_valid,
   input  wire logic [akic_pkg::KEY_LOW_W-1:0]      key_low,
   input  wire logic [akic_pkg::KEY_HIGH_W-1:0]     key_high,
   input  wire logic [akic_pkg::TIME_W-1:0]         now_ms,
   input  wire logic [akic_pkg::TIMEOUT_W-1:0]      timeout_ms,
   output akic_pkg::cmp_result_type                 result
);

   logic [akic_pkg::TIME_W-1:0] age;

   // wrapping age
   assign age = now_ms - entry.last_use;

   assign result.hit = slot_valid && (entry.key_low == key_low)
                       && (entry.key_high == key_high);
   assign result.expired = slot_valid
                           && (age > {1'b0, timeout_ms});

endmodule

`default_nettype wire

// File: rtl/aging_key_index_cache.sv
// Small key-to-index table with aging. An item is taken when start is high and busy is low;
// busy then stays high until the item is done. Every action first reads the entry RAM one
// slot per cycle through a single compare unit; lookup, add and delete end early on the
// first hit, a sweep always reads every slot. An add that misses, with a non-negative
// directory index, then steps through the valid bits one slot per cycle from the slot after
// the insert cursor, checking up to ENTRIES slots. Add and lookup give one result, shown for
// exactly one cycle with rsp_valid; the receiver cannot stall it. Delete and sweep give none.
// from_cache marks an index taken from a cached entry, which the caller may still have to
// check against its connection state. The timeout register is written with csr_wr_en; the
// user must change it only while busy is low, as the block itself does not enforce this.
// Valid bits clear at reset, so there is no clearing pass.

`default_nettype none

module aging_key_index_cache #(
   parameter int ENTRIES = akic_pkg::ENTRIES_DEFAULT
) (
   input  wire logic                                     clock,
   input  wire logic                                     reset,
   input  wire logic                                     start,
   output logic                                          busy,
   input  wire logic [1:0]                               req_action,
   input  wire logic [akic_pkg::KEY_LOW_W-1:0]           req_key_low,
   input  wire logic [akic_pkg::KEY_HIGH_W-1:0]          req_key_high,
   input  wire logic signed [akic_pkg::INDEX_W-1:0]      req_directory_index,
   input  wire logic [akic_pkg::TIME_W-1:0]              req_now_ms,
   output logic                                          rsp_valid,
   output logic signed [akic_pkg::INDEX_W-1:0]           rsp_result_index,
   output logic                                          rsp_from_cache,
   input  wire logic                                     csr_wr_en,
   input  wire logic [akic_pkg::TIMEOUT_W-1:0]           csr_wr_data
);

   localparam int IDX_W = $clog2(ENTRIES);
   localparam int CNT_W = $clog2(ENTRIES + 1);
   localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(ENTRIES - 1);
   localparam logic [CNT_W-1:0] SCAN_END = CNT_W'(ENTRIES);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SCAN = 2'd1;
   localparam logic [1:0] ST_FREE = 2'd2;

   function automatic logic [IDX_W-1:0] next_slot(input logic [IDX_W-1:0] s);
      next_slot = (s == LAST_SLOT) ? '0 : s + IDX_W'(1);
   endfunction

   logic [1:0] state_ff, state_in;
   logic [1:0] action_ff, action_in;
   logic [akic_pkg::KEY_LOW_W-1:0] key_low_ff, key_low_in;
   logic [akic_pkg::KEY_HIGH_W-1:0] key_high_ff, key_high_in;
   logic signed [akic_pkg::INDEX_W-1:0] dir_ff, dir_in;
   logic [akic_pkg::TIME_W-1:0] now_ff, now_in;
   logic [CNT_W-1:0] issue_cnt_ff, issue_cnt_in;
   logic cmp_live_ff, cmp_live_in;
   logic [IDX_W-1:0] cmp_slot_ff, cmp_slot_in;
   logic [IDX_W-1:0] free_ptr_ff, free_ptr_in;
   logic [IDX_W-1:0] free_cnt_ff, free_cnt_in;
   logic [IDX_W-1:0] cursor_ff, cursor_in;
   logic [ENTRIES-1:0] valid_ff, valid_in;
   logic [akic_pkg::TIMEOUT_W-1:0] timeout_ff, timeout_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic signed [akic_pkg::INDEX_W-1:0] rsp_index_ff, rsp_index_in;
   logic rsp_cache_ff, rsp_cache_in;

   logic [akic_pkg::KEY_LOW_W-1:0] norm_low;
   logic [akic_pkg::KEY_HIGH_W-1:0] norm_high;
   logic accept;

   logic ram_wr_en;
   logic [IDX_W-1:0] ram_wr_addr;
   akic_pkg::entry_type ram_wr_data;
   logic [IDX_W-1:0] ram_rd_addr;
   akic_pkg::entry_type ram_rd_data;
   akic_pkg::cmp_result_type cmp;

   assign accept = start && (state_ff == ST_IDLE);

   akic_key_norm u_key_norm (
      .key_low   (req_key_low),
      .key_high  (req_key_high),
      .norm_low  (norm_low),
      .norm_high (norm_high)
   );

   akic_ram #(
      .WIDTH ($bits(akic_pkg::entry_type)),
      .DEPTH (ENTRIES)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   akic_cmp_unit u_cmp_unit (
      .entry      (ram_rd_data),
      .slot_valid (valid_ff[cmp_slot_ff]),
      .key_low    (key_low_ff),
      .key_high   (key_high_ff),
      .now_ms     (now_ff),
      .timeout_ms (timeout_ff),
      .result     (cmp)
   );

   always_comb begin
      state_in = state_ff;
      action_in = action_ff;
      key_low_in = key_low_ff;
      key_high_in = key_high_ff;
      dir_in = dir_ff;
      now_in = now_ff;
      issue_cnt_in = issue_cnt_ff;
      cmp_live_in = 1'b0;
      cmp_slot_in = cmp_slot_ff;
      free_ptr_in = free_ptr_ff;
      free_cnt_in = free_cnt_ff;
      cursor_in = cursor_ff;
      valid_in = valid_ff;
      timeout_in = csr_wr_en ? csr_wr_data : timeout_ff;
      rsp_valid_in = 1'b0;
      rsp_index_in = rsp_index_ff;
      rsp_cache_in = rsp_cache_ff;
      ram_wr_en = 1'b0;
      ram_wr_addr = cmp_slot_ff;
      ram_wr_data = ram_rd_data;
      ram_rd_addr = issue_cnt_ff[IDX_W-1:0];

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_SCAN;
               action_in = req_action;
               key_low_in = norm_low;
               key_high_in = norm_high;
               dir_in = req_directory_index;
               now_in = req_now_ms;
               issue_cnt_in = '0;
            end
         end
         ST_SCAN: begin
            // read one slot, compare the one read last cycle
            if (issue_cnt_ff != SCAN_END) begin
               issue_cnt_in = issue_cnt_ff + CNT_W'(1);
               cmp_live_in = 1'b1;
               cmp_slot_in = issue_cnt_ff[IDX_W-1:0];
            end
            if (cmp_live_ff) begin
               case (action_ff)
                  akic_pkg::ACT_SWEEP: begin
                     if (cmp.expired) begin
                        valid_in[cmp_slot_ff] = 1'b0;
                     end
                     if (cmp_slot_ff == LAST_SLOT) begin
                        state_in = ST_IDLE;
                     end
                  end
                  akic_pkg::ACT_DELETE: begin
                     if (cmp.hit) begin
                        valid_in[cmp_slot_ff] = 1'b0;
                        state_in = ST_IDLE;
                     end else if (cmp_slot_ff == LAST_SLOT) begin
                        state_in = ST_IDLE;
                     end
                  end
                  default: begin
                     if (cmp.hit) begin
                        // refresh last use
                        ram_wr_en = 1'b1;
                        ram_wr_addr = cmp_slot_ff;
                        ram_wr_data = ram_rd_data;
                        ram_wr_data.last_use = now_ff;
                        rsp_valid_in = 1'b1;
                        rsp_index_in = ram_rd_data.index;
                        rsp_cache_in = 1'b1;
                        state_in = ST_IDLE;
                     end else if (cmp_slot_ff == LAST_SLOT) begin
                        if ((action_ff == akic_pkg::ACT_LOOKUP) || dir_ff[akic_pkg::INDEX_W-1]) begin
                           rsp_valid_in = 1'b1;
                           rsp_index_in = akic_pkg::NO_INDEX;
                           rsp_cache_in = 1'b0;
                           state_in = ST_IDLE;
                        end else begin
                           free_ptr_in = next_slot(cursor_ff);
                           free_cnt_in = '0;
                           state_in = ST_FREE;
                        end
                     end
                  end
               endcase
            end
         end
         ST_FREE: begin
            if (!valid_ff[free_ptr_ff]) begin
               ram_wr_en = 1'b1;
               ram_wr_addr = free_ptr_ff;
               ram_wr_data.key_low = key_low_ff;
               ram_wr_data.key_high = key_high_ff;
               ram_wr_data.index = dir_ff;
               ram_wr_data.last_use = now_ff;
               valid_in[free_ptr_ff] = 1'b1;
               cursor_in = next_slot(cursor_ff);
               rsp_valid_in = 1'b1;
               rsp_index_in = dir_ff;
               rsp_cache_in = 1'b0;
               state_in = ST_IDLE;
            end else if (free_cnt_ff == LAST_SLOT) begin
               // table full
               rsp_valid_in = 1'b1;
               rsp_index_in = dir_ff;
               rsp_cache_in = 1'b0;
               state_in = ST_IDLE;
            end else begin
               free_ptr_in = next_slot(free_ptr_ff);
               free_cnt_in = free_cnt_ff + IDX_W'(1);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cmp_live_ff <= 1'b0;
         cursor_ff <= '0;
         valid_ff <= '0;
         timeout_ff <= akic_pkg::TIMEOUT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cmp_live_ff <= cmp_live_in;
         cursor_ff <= cursor_in;
         valid_ff <= valid_in;
         timeout_ff <= timeout_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      action_ff <= action_in;
      key_low_ff <= key_low_in;
      key_high_ff <= key_high_in;
      dir_ff <= dir_in;
      now_ff <= now_in;
      issue_cnt_ff <= issue_cnt_in;
      cmp_slot_ff <= cmp_slot_in;
      free_ptr_ff <= free_ptr_in;
      free_cnt_ff <= free_cnt_in;
      rsp_index_ff <= rsp_index_in;
      rsp_cache_ff <= rsp_cache_in;
   end

   assign busy = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_result_index = rsp_index_ff;
   assign rsp_from_cache = rsp_cache_ff;

endmodule

`default_nettype wire

// File: rtl/akic_checker.sv
`default_nettype none

module akic_checker (
   input  wire logic                                     clock,
   input  wire logic                                     reset,
   input  wire logic                                     start,
   input  wire logic                                     busy,
   input  wire logic                                     rsp_valid,
   input  wire logic                                     rsp_from_cache,
   input  wire logic                                     csr_wr_en
);

   // a beat on the result side closes a busy period
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy) && !busy)
      else $error("result beat without a preceding busy period");

   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted request did not raise busy");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("two result beats in a row");

   assert property (@(posedge clock)
      reset |=> !busy && !rsp_valid)
      else $error("busy or result beat right after reset");

   assert property (@(posedge clock) disable iff (reset)
      rsp_from_cache && rsp_valid |-> !$past(csr_wr_en))
      else $error("cache hit reported right after a timeout write");

endmodule

bind aging_key_index_cache akic_checker u_akic_checker (
   .clock          (clock),
   .reset          (reset),
   .start          (start),
   .busy           (busy),
   .rsp_valid      (rsp_valid),
   .rsp_from_cache (rsp_from_cache),
   .csr_wr_en      (csr_wr_en)
);

`default_nettype wire
